// ===== hdl/assert_macros.svh =====
// concurrent assertion helpers, sampled on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every sampled edge
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true at a sampled edge
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== hdl/qapt_pkg.sv =====
`timescale 1ns / 1ps
package qapt_pkg;

  localparam int unsigned QW        = 16;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned ERR_W     = 34;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned PA_W      = GAIN_W + 1 + ERR_W;
  localparam int unsigned PR_W      = GAIN_W + 1 + QW;
  localparam int unsigned SUM_W     = 52;
  localparam int unsigned TRQ_W     = 24;
  localparam int unsigned ALIGN_RATE = 18;
  localparam int unsigned DROP_BITS = 27;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ATT_GAIN  = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_RATE_GAIN = cfg_idx_t'(1);

  localparam logic [GAIN_W-1:0] ATT_GAIN_RST  = GAIN_W'(5120);
  localparam logic [GAIN_W-1:0] RATE_GAIN_RST = GAIN_W'(1024);

  localparam logic signed [TRQ_W-1:0] TRQ_MAX = {1'b0, {(TRQ_W-1){1'b1}}};
  localparam logic signed [TRQ_W-1:0] TRQ_MIN = {1'b1, {(TRQ_W-1){1'b0}}};

  typedef struct packed {
    logic signed [QW-1:0] q0;
    logic signed [QW-1:0] q1;
    logic signed [QW-1:0] q2;
    logic signed [QW-1:0] q3;
  } quat_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } rate_t;

  // error vector as it leaves the product stages, flip set when scalar part < 0
  typedef struct packed {
    logic                    flip;
    logic signed [ERR_W-1:0] x;
    logic signed [ERR_W-1:0] y;
    logic signed [ERR_W-1:0] z;
    rate_t                   rate;
  } qerr_t;

  typedef struct packed {
    logic [1:0] vld;
  } mul_sts_t;

  typedef struct packed {
    logic [2:0] vld;
  } trq_sts_t;

endpackage

// ===== hdl/qapt_quat_mul.sv =====
`timescale 1ns / 1ps
module qapt_quat_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  qapt_pkg::quat_t  ref_i,
  input  qapt_pkg::quat_t  meas_i,
  input  qapt_pkg::rate_t  rate_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output qapt_pkg::qerr_t  err_o,
  output qapt_pkg::mul_sts_t sts_o
);
  import qapt_pkg::*;

  logic signed [QW-1:0]     a [4];
  logic signed [QW-1:0]     b [4];
  logic signed [PROD_W-1:0] prod_d [16];
  logic signed [PROD_W-1:0] prod_q [16];
  rate_t                    s1_rate_q;
  logic                     s1_vld_q;
  logic                     s2_vld_q;
  qerr_t                    err_d;
  qerr_t                    err_q;
  logic                     adv1;
  logic                     adv2;
  logic signed [ERR_W-1:0]  e0;

  assign adv2       = !s2_vld_q || out_ready_i;
  assign adv1       = !s1_vld_q || adv2;
  assign in_ready_o = adv1;

  assign a[0] = ref_i.q0;
  assign a[1] = ref_i.q1;
  assign a[2] = ref_i.q2;
  assign a[3] = ref_i.q3;
  assign b[0] = meas_i.q0;
  assign b[1] = meas_i.q1;
  assign b[2] = meas_i.q2;
  assign b[3] = meas_i.q3;

  // stage 1: all sixteen partial products, index is ref*4 + meas
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_d[i*4+j] = a[i] * b[j];
      end
    end
  end

  // stage 2: hamilton product ref * meas
  always_comb begin
    e0 = ERR_W'(prod_q[0]) - ERR_W'(prod_q[5]) - ERR_W'(prod_q[10]) - ERR_W'(prod_q[15]);
    err_d.x = ERR_W'(prod_q[1]) + ERR_W'(prod_q[4]) + ERR_W'(prod_q[11])
            - ERR_W'(prod_q[14]);
    err_d.y = ERR_W'(prod_q[2]) - ERR_W'(prod_q[7]) + ERR_W'(prod_q[8])
            + ERR_W'(prod_q[13]);
    err_d.z = ERR_W'(prod_q[3]) + ERR_W'(prod_q[6]) - ERR_W'(prod_q[9])
            + ERR_W'(prod_q[12]);
    err_d.flip = e0[ERR_W-1];
    err_d.rate = s1_rate_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (adv1) s1_vld_q <= in_valid_i;
      if (adv2) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      prod_q    <= prod_d;
      s1_rate_q <= rate_i;
    end
    if (adv2 && s1_vld_q) begin
      err_q <= err_d;
    end
  end

  assign out_valid_o = s2_vld_q;
  assign err_o       = err_q;
  assign sts_o.vld   = {s2_vld_q, s1_vld_q};

endmodule

// ===== hdl/qapt_torque.sv =====
`timescale 1ns / 1ps
module qapt_torque (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [qapt_pkg::GAIN_W-1:0]          att_gain_i,
  input  logic [qapt_pkg::GAIN_W-1:0]          rate_gain_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  qapt_pkg::qerr_t                      err_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [qapt_pkg::TRQ_W-1:0]    torque_x_o,
  output logic signed [qapt_pkg::TRQ_W-1:0]    torque_y_o,
  output logic signed [qapt_pkg::TRQ_W-1:0]    torque_z_o,
  output qapt_pkg::trq_sts_t                   sts_o
);
  import qapt_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (DROP_BITS - 1);

  logic signed [ERR_W-1:0] err [3];
  logic signed [QW-1:0]    rate [3];
  logic signed [PA_W-1:0]  pa_d [3];
  logic signed [PA_W-1:0]  pa_q [3];
  logic signed [PR_W-1:0]  pr_d [3];
  logic signed [PR_W-1:0]  pr_q [3];
  logic                    flip_q;
  logic signed [SUM_W-1:0] sum_d [3];
  logic signed [SUM_W-1:0] sum_q [3];
  logic signed [TRQ_W-1:0] trq_d [3];
  logic signed [TRQ_W-1:0] trq_q [3];
  logic                    s3_vld_q;
  logic                    s4_vld_q;
  logic                    s5_vld_q;
  logic                    adv3;
  logic                    adv4;
  logic                    adv5;

  assign adv5       = !s5_vld_q || out_ready_i;
  assign adv4       = !s4_vld_q || adv5;
  assign adv3       = !s3_vld_q || adv4;
  assign in_ready_o = adv3;

  assign err[0]  = err_i.x;
  assign err[1]  = err_i.y;
  assign err[2]  = err_i.z;
  assign rate[0] = err_i.rate.x;
  assign rate[1] = err_i.rate.y;
  assign rate[2] = err_i.rate.z;

  // stage 3: gain products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_d[k] = $signed({1'b0, att_gain_i}) * err[k];
      pr_d[k] = $signed({1'b0, rate_gain_i}) * rate[k];
    end
  end

  // stage 4: -kq*e - kw*w aligned at 2^-38, sign of e folded in, plus half lsb
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = (flip_q ? SUM_W'(pa_q[k]) : -SUM_W'(pa_q[k]))
               - (SUM_W'(pr_q[k]) <<< ALIGN_RATE) + ROUND_BIAS;
    end
  end

  // stage 5: floor to 2^-11 and clamp
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (sum_q[k][SUM_W-1] != sum_q[k][DROP_BITS+TRQ_W-1]) begin
        trq_d[k] = sum_q[k][SUM_W-1] ? TRQ_MIN : TRQ_MAX;
      end else begin
        trq_d[k] = sum_q[k][DROP_BITS+TRQ_W-1:DROP_BITS];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      if (adv3) s3_vld_q <= in_valid_i;
      if (adv4) s4_vld_q <= s3_vld_q;
      if (adv5) s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && in_valid_i) begin
      pa_q   <= pa_d;
      pr_q   <= pr_d;
      flip_q <= err_i.flip;
    end
    if (adv4 && s3_vld_q) begin
      sum_q <= sum_d;
    end
    if (adv5 && s4_vld_q) begin
      trq_q <= trq_d;
    end
  end

  assign out_valid_o = s5_vld_q;
  assign torque_x_o  = trq_q[0];
  assign torque_y_o  = trq_q[1];
  assign torque_z_o  = trq_q[2];
  assign sts_o.vld   = {s5_vld_q, s4_vld_q, s3_vld_q};

endmodule

// ===== hdl/quaternion_attitude_pd_torque.sv =====
`timescale 1ns / 1ps
// channel   dir  transfer when              payload
// input     in   in_valid_i && !in_stall_o  ref_q0..3, meas_q0..3, rate_x/y/z
// output    out  out_valid_o && !out_stall_i torque_x/y/z (Q12.11, saturated)
// config    in   cfg_we_i                   cfg_idx_i selects gain, cfg_data_i
//
// one transfer in per cycle sustained while the output is not stalled; the
// result passes through one register each for: partial products, hamilton sum,
// gain multiply, sum and round, clamp
// every stage holds its item while the next one is full, so a stall on the
// output backs up stage by stage and nothing is dropped or repeated
// reset clears all stage valid bits and loads gains 20.0 and 4.0
`include "assert_macros.svh"
module quaternion_attitude_pd_torque (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [qapt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [qapt_pkg::GAIN_W-1:0]          cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [qapt_pkg::QW-1:0]       ref_q0_i,
  input  logic signed [qapt_pkg::QW-1:0]       ref_q1_i,
  input  logic signed [qapt_pkg::QW-1:0]       ref_q2_i,
  input  logic signed [qapt_pkg::QW-1:0]       ref_q3_i,
  input  logic signed [qapt_pkg::QW-1:0]       meas_q0_i,
  input  logic signed [qapt_pkg::QW-1:0]       meas_q1_i,
  input  logic signed [qapt_pkg::QW-1:0]       meas_q2_i,
  input  logic signed [qapt_pkg::QW-1:0]       meas_q3_i,
  input  logic signed [qapt_pkg::QW-1:0]       rate_x_i,
  input  logic signed [qapt_pkg::QW-1:0]       rate_y_i,
  input  logic signed [qapt_pkg::QW-1:0]       rate_z_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [qapt_pkg::TRQ_W-1:0]    torque_x_o,
  output logic signed [qapt_pkg::TRQ_W-1:0]    torque_y_o,
  output logic signed [qapt_pkg::TRQ_W-1:0]    torque_z_o
);
  import qapt_pkg::*;

  // gain registers, unsigned Q8.8
  logic [GAIN_W-1:0] att_gain_q;
  logic [GAIN_W-1:0] rate_gain_q;

  quat_t    ref_in;
  quat_t    meas_in;
  rate_t    rate_in;
  qerr_t    err;
  logic     mul_ready;
  logic     mul_valid;
  logic     trq_ready;
  mul_sts_t mul_sts;
  trq_sts_t trq_sts;

  // writes to an index past the gain list fall through and change nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_gain_q  <= ATT_GAIN_RST;
      rate_gain_q <= RATE_GAIN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ATT_GAIN)  att_gain_q  <= cfg_data_i;
      if (cfg_idx_i == CFG_RATE_GAIN) rate_gain_q <= cfg_data_i;
    end
  end

  assign ref_in  = '{q0: ref_q0_i,  q1: ref_q1_i,  q2: ref_q2_i,  q3: ref_q3_i};
  assign meas_in = '{q0: meas_q0_i, q1: meas_q1_i, q2: meas_q2_i, q3: meas_q3_i};
  assign rate_in = '{x: rate_x_i, y: rate_y_i, z: rate_z_i};

  // stages 1-2: partial products and the quaternion error with its sign flag
  qapt_quat_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (mul_ready),
    .ref_i       (ref_in),
    .meas_i      (meas_in),
    .rate_i      (rate_in),
    .out_valid_o (mul_valid),
    .out_ready_i (trq_ready),
    .err_o       (err),
    .sts_o       (mul_sts)
  );

  // stages 3-5: gain multiply, combine and round, clamp into the output register
  qapt_torque u_trq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .att_gain_i  (att_gain_q),
    .rate_gain_i (rate_gain_q),
    .in_valid_i  (mul_valid),
    .in_ready_o  (trq_ready),
    .err_i       (err),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .torque_x_o  (torque_x_o),
    .torque_y_o  (torque_y_o),
    .torque_z_o  (torque_z_o),
    .sts_o       (trq_sts)
  );

  // input stalls only when the first stage cannot move
  assign in_stall_o = !mul_ready;

  // a stall on the input can only come from a full pipe held by the output
  `ASSERT_CLK(a_stall_full, in_stall_o |-> (&mul_sts.vld && &trq_sts.vld), "stall with a bubble in the pipe")
  `ASSERT_NEVER(a_stall_src, in_stall_o && !out_stall_i, "input stalled while output drains")
  `ASSERT_CLK(a_att_wr, (rst_ni && cfg_we_i && cfg_idx_i == CFG_ATT_GAIN) |=> (att_gain_q == $past(cfg_data_i)), "attitude gain write lost")
  `ASSERT_CLK(a_rate_wr, (rst_ni && cfg_we_i && cfg_idx_i == CFG_RATE_GAIN) |=> (rate_gain_q == $past(cfg_data_i)), "rate gain write lost")

endmodule
